FILE: hw/rtl/psd_pkg.sv
// Shared types, constants and helpers for the point-to-segment distance block.
package psd_pkg;

	localparam int COORD_FRAC_BITS = 16;
	localparam int QUO_BITS        = 32;	// projection fraction bits
	localparam int ROOT_BITS       = 41;	// root bits produced by the sqrt row
	localparam int ROOT_IDX_W      = 6;

	localparam logic [32:0] DIST_MAX  = 33'd6074001000;
	localparam logic [32:0] TOL_RESET = 33'(64'd1 << COORD_FRAC_BITS);

	typedef enum logic [1:0] {
		PART_START = 2'd0,
		PART_END   = 2'd1,
		PART_MID   = 2'd2
	} part_t;

	typedef struct packed {
		logic signed [31:0] start_x;
		logic signed [31:0] start_y;
		logic signed [31:0] end_x;
		logic signed [31:0] end_y;
		logic signed [31:0] query_x;
		logic signed [31:0] query_y;
	} req_t;

	typedef struct packed {
		logic [32:0] distance;
		logic        is_near;
		logic [1:0]  nearest_part;
	} res_t;

	// geometry carried alongside the divider row
	typedef struct packed {
		logic signed [32:0] vx;
		logic signed [32:0] vy;
		logic signed [32:0] wx;
		logic signed [32:0] wy;
		logic signed [32:0] dx0;
		logic signed [32:0] dy0;
		part_t              part;
	} geo_t;

	typedef struct packed {
		logic [67:0]         rem;
		logic [66:0]         den;
		logic [QUO_BITS-1:0] quo;
		geo_t                geo;
	} div_t;

	typedef struct packed {
		logic [71:0]          rem;
		logic [ROOT_BITS-1:0] root;
		part_t                part;
	} sq_t;

	function automatic logic [32:0] mag33(input logic signed [32:0] v);
		return v[32] ? 33'(-v) : 33'(v);
	endfunction

	function automatic logic [34:0] mag35(input logic signed [34:0] v);
		return v[34] ? 35'(-v) : 35'(v);
	endfunction

endpackage

FILE: hw/rtl/point_segment_distance_top.sv
// Top level of the point-to-segment distance pipeline.
//
// Usage:
//  - A request (segment start, segment end, query point, signed Q16.16) is
//    taken at a rising edge with start high and busy low. busy is held low:
//    a new request may be issued every cycle.
//  - Each request gives one result: distance (unsigned Q17.16, saturated),
//    is_near and nearest_part. done is high for exactly one cycle with the
//    result; the receiver cannot stall, so results must be taken as shown.
//  - The pipeline has six set-up stages (offsets, products, dot products,
//    case decision), a row of 32 divider cells for the projection
//    fraction, four stages for scaling and squaring, a row of 41
//    square-root cells and the output register. Throughput: one per cycle.
//  - Results come out in request order; no state is shared between requests.
//  - cfg_we / cfg_wdata write the near tolerance; write it only while no
//    request is in flight. Reset sets it to 1.0 and empties the pipeline.
module point_segment_distance_top (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  psd_pkg::req_t   req,
	output logic            done,
	output psd_pkg::res_t   result,
	input  logic            cfg_we,
	input  logic [32:0]     cfg_wdata
);
	import psd_pkg::*;

	logic [32:0] tol_q;

	// valid flags of the front and back stages
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;

	req_t               req_s1;
	logic signed [32:0] vx_s2, vy_s2, wx_s2, wy_s2, ex_s2, ey_s2;
	logic [65:0]        pxm_s3, pym_s3, vxx_s3, vyy_s3;
	logic               nx_s3, ny_s3;
	geo_t               g_s3, g_s4, g_s5;
	logic [66:0]        pos_s4, neg_s4, c2_s4;
	logic               le0_s5;
	logic [66:0]        c1_s5, c2_s5;
	div_t               d_s6;

	logic [64:0]        tx_s7, ty_s7;
	geo_t               g_s7;
	logic signed [34:0] dx_s8, dy_s8;
	part_t              part_s8, part_s9;
	logic [69:0]        sqx_s9, sqy_s9;
	sq_t                sq_s10;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
		end else if (cfg_we) begin
			tol_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6} <= '0;
		end else begin
			v_s1 <= start & ~busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// front end: offsets, products, dot products, case decision
	always_ff @(posedge clk) begin
		req_s1 <= req;

		vx_s2 <= 33'(req_s1.end_x)   - 33'(req_s1.start_x);
		vy_s2 <= 33'(req_s1.end_y)   - 33'(req_s1.start_y);
		wx_s2 <= 33'(req_s1.query_x) - 33'(req_s1.start_x);
		wy_s2 <= 33'(req_s1.query_y) - 33'(req_s1.start_y);
		ex_s2 <= 33'(req_s1.query_x) - 33'(req_s1.end_x);
		ey_s2 <= 33'(req_s1.query_y) - 33'(req_s1.end_y);

		pxm_s3 <= mag33(vx_s2) * mag33(wx_s2);
		pym_s3 <= mag33(vy_s2) * mag33(wy_s2);
		vxx_s3 <= mag33(vx_s2) * mag33(vx_s2);
		vyy_s3 <= mag33(vy_s2) * mag33(vy_s2);
		nx_s3  <= vx_s2[32] ^ wx_s2[32];
		ny_s3  <= vy_s2[32] ^ wy_s2[32];
		g_s3   <= '{vx: vx_s2, vy: vy_s2, wx: wx_s2, wy: wy_s2,
		            dx0: ex_s2, dy0: ey_s2, part: PART_START};

		pos_s4 <= (nx_s3 ? 67'd0 : 67'(pxm_s3)) + (ny_s3 ? 67'd0 : 67'(pym_s3));
		neg_s4 <= (nx_s3 ? 67'(pxm_s3) : 67'd0) + (ny_s3 ? 67'(pym_s3) : 67'd0);
		c2_s4  <= 67'(vxx_s3) + 67'(vyy_s3);
		g_s4   <= g_s3;

		le0_s5 <= pos_s4 <= neg_s4;
		c1_s5  <= pos_s4 - neg_s4;
		c2_s5  <= c2_s4;
		g_s5   <= g_s4;

		// dx0/dy0 hold the end-point offset until here
		d_s6.den    <= c2_s5;
		d_s6.quo    <= '0;
		d_s6.geo.vx <= g_s5.vx;
		d_s6.geo.vy <= g_s5.vy;
		d_s6.geo.wx <= g_s5.wx;
		d_s6.geo.wy <= g_s5.wy;
		if (le0_s5) begin
			d_s6.rem      <= '0;
			d_s6.geo.dx0  <= g_s5.wx;
			d_s6.geo.dy0  <= g_s5.wy;
			d_s6.geo.part <= PART_START;
		end else if (c2_s5 <= c1_s5) begin
			d_s6.rem      <= '0;
			d_s6.geo.dx0  <= g_s5.dx0;
			d_s6.geo.dy0  <= g_s5.dy0;
			d_s6.geo.part <= PART_END;
		end else begin
			d_s6.rem      <= {1'b0, c1_s5};
			d_s6.geo.dx0  <= g_s5.dx0;
			d_s6.geo.dy0  <= g_s5.dy0;
			d_s6.geo.part <= PART_MID;
		end
	end

	// divider row: t = floor(c1 * 2^32 / c2)
	div_t div_d [QUO_BITS+1];
	logic div_v [QUO_BITS+1];

	assign div_d[0] = d_s6;
	assign div_v[0] = v_s6;

	for (genvar k = 0; k < QUO_BITS; k++) begin : g_div
		psd_div_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.vld_in  (div_v[k]),
			.d_in    (div_d[k]),
			.vld_out (div_v[k+1]),
			.d_out   (div_d[k+1])
		);
	end

	// scale, pick offset, square, sum
	logic [32:0]        mx_s8, my_s8;
	logic signed [34:0] sx_s8, sy_s8;

	always_comb begin
		mx_s8 = tx_s7[64:32];
		my_s8 = ty_s7[64:32];
		sx_s8 = g_s7.vx[32] ? -35'(mx_s8) : 35'(mx_s8);
		sy_s8 = g_s7.vy[32] ? -35'(my_s8) : 35'(my_s8);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s7, v_s8, v_s9, v_s10} <= '0;
		end else begin
			v_s7  <= div_v[QUO_BITS];
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		tx_s7 <= div_d[QUO_BITS].quo * mag33(div_d[QUO_BITS].geo.vx);
		ty_s7 <= div_d[QUO_BITS].quo * mag33(div_d[QUO_BITS].geo.vy);
		g_s7  <= div_d[QUO_BITS].geo;

		if (g_s7.part == PART_MID) begin
			dx_s8 <= 35'(g_s7.wx) - sx_s8;
			dy_s8 <= 35'(g_s7.wy) - sy_s8;
		end else begin
			dx_s8 <= 35'(g_s7.dx0);
			dy_s8 <= 35'(g_s7.dy0);
		end
		part_s8 <= g_s7.part;

		sqx_s9  <= mag35(dx_s8) * mag35(dx_s8);
		sqy_s9  <= mag35(dy_s8) * mag35(dy_s8);
		part_s9 <= part_s8;

		sq_s10.rem  <= 72'(sqx_s9) + 72'(sqy_s9);
		sq_s10.root <= '0;
		sq_s10.part <= part_s9;
	end

	// square-root row, most significant root bit first
	sq_t  sq_d [ROOT_BITS+1];
	logic sq_v [ROOT_BITS+1];

	assign sq_d[0] = sq_s10;
	assign sq_v[0] = v_s10;

	for (genvar k = 0; k < ROOT_BITS; k++) begin : g_sqrt
		psd_sqrt_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.bit_idx (ROOT_IDX_W'(ROOT_BITS - 1 - k)),
			.vld_in  (sq_v[k]),
			.s_in    (sq_d[k]),
			.vld_out (sq_v[k+1]),
			.s_out   (sq_d[k+1])
		);
	end

	// saturate, compare, present
	logic [32:0] dist_c;

	assign dist_c = (sq_d[ROOT_BITS].root > ROOT_BITS'(DIST_MAX)) ? DIST_MAX
		: sq_d[ROOT_BITS].root[32:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= sq_v[ROOT_BITS];
		end
	end

	always_ff @(posedge clk) begin
		result.distance     <= dist_c;
		result.is_near      <= dist_c <= tol_q;
		result.nearest_part <= sq_d[ROOT_BITS].part;
	end

	// checks
	a_dist_sat: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.distance <= DIST_MAX)
		else $error("distance above saturation limit");

	a_near_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.is_near == (result.distance <= tol_q))
		else $error("near flag disagrees with tolerance");

	a_part_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.nearest_part <= PART_MID)
		else $error("nearest part code out of range");

endmodule

FILE: hw/rtl/psd_div_cell.sv
// One restoring-division cell: yields one quotient bit per request per cycle.
module psd_div_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           vld_in,
	input  psd_pkg::div_t  d_in,
	output logic           vld_out,
	output psd_pkg::div_t  d_out
);
	import psd_pkg::*;

	logic [67:0] rem_dbl;
	logic [67:0] den_ext;
	logic        take;
	div_t        d_nxt;

	always_comb begin
		rem_dbl = {d_in.rem[66:0], 1'b0};
		den_ext = {1'b0, d_in.den};
		take    = rem_dbl >= den_ext;
		d_nxt     = d_in;
		d_nxt.rem = take ? rem_dbl - den_ext : rem_dbl;
		d_nxt.quo = {d_in.quo[QUO_BITS-2:0], take};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else begin
			vld_out <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		d_out <= d_nxt;
	end

endmodule

FILE: hw/rtl/psd_sqrt_cell.sv
// One square-root cell: decides one root bit, remainder kept as n - root^2.
module psd_sqrt_cell (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [psd_pkg::ROOT_IDX_W-1:0] bit_idx,
	input  logic                           vld_in,
	input  psd_pkg::sq_t                   s_in,
	output logic                           vld_out,
	output psd_pkg::sq_t                   s_out
);
	import psd_pkg::*;

	logic [83:0] term;
	logic        take;
	sq_t         s_nxt;

	always_comb begin
		// (2r + 2^b) * 2^b
		term  = ((84'(s_in.root) << 1) | (84'd1 << bit_idx)) << bit_idx;
		take  = term <= 84'(s_in.rem);
		s_nxt = s_in;
		if (take) begin
			s_nxt.rem  = s_in.rem - term[71:0];
			s_nxt.root = s_in.root | (ROOT_BITS'(1) << bit_idx);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else begin
			vld_out <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		s_out <= s_nxt;
	end

endmodule

FILE: bench/tb.sv
// Self-checking testbench for point_segment_distance_top.
`timescale 1ns / 1ps

module tb;
	import psd_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 100;	// longer than the pipeline latency

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	req_t        req;
	logic        done;
	res_t        result;
	logic        cfg_we;
	logic [32:0] cfg_wdata;

	point_segment_distance_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// Tolerance as the block should currently hold it.
	logic [32:0] tolerance;
	res_t        pending_q[$];
	int          mismatches;
	int          quiet_cycles;
	int          idle_pct;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Truncating t * v / 2^32 with the sign of v.
	function automatic longint proj_offset(logic [127:0] t, longint v);
		logic [127:0] m;
		logic [127:0] mg;
		mg = v < 0 ? 128'(-v) : 128'(v);
		m  = (t * mg) >> 32;
		return v < 0 ? -longint'(m) : longint'(m);
	endfunction

	// Expected result of one request under tolerance tol.
	function automatic res_t seg_distance(req_t r, logic [32:0] tol);
		longint sx, sy, ex, ey, qx, qy, vx, vy, wx, wy, dx, dy;
		logic signed [127:0] c1, c2;
		logic [127:0] t, n, root, cand;
		part_t part;
		res_t o;
		sx = r.start_x; sy = r.start_y;
		ex = r.end_x;   ey = r.end_y;
		qx = r.query_x; qy = r.query_y;
		vx = ex - sx; vy = ey - sy;
		wx = qx - sx; wy = qy - sy;
		c1 = 128'(vx) * 128'(wx) + 128'(vy) * 128'(wy);
		c2 = 128'(vx) * 128'(vx) + 128'(vy) * 128'(vy);
		if (c1 <= 0) begin
			dx = wx; dy = wy; part = PART_START;
		end else if (c2 <= c1) begin
			dx = qx - ex; dy = qy - ey; part = PART_END;
		end else begin
			t  = (c1 <<< 32) / c2;
			dx = wx - proj_offset(t, vx);
			dy = wy - proj_offset(t, vy);
			part = PART_MID;
		end
		n = 128'(128'(dx) * 128'(dx)) + 128'(128'(dy) * 128'(dy));
		root = '0;
		for (int b = 40; b >= 0; b--) begin
			cand = root | (128'(1) << b);
			if (cand * cand <= n)
				root = cand;
		end
		if (root > 128'(DIST_MAX))
			root = 128'(DIST_MAX);
		o.distance     = root[32:0];
		o.is_near      = root[32:0] <= tol;
		o.nearest_part = part;
		return o;
	endfunction

	function automatic req_t mk_req(int a, int b, int c, int d, int e, int f);
		req_t r;
		r.start_x = a; r.start_y = b;
		r.end_x   = c; r.end_y   = d;
		r.query_x = e; r.query_y = f;
		return r;
	endfunction

	// Random request: mostly small, well-placed geometry; some full-range noise.
	function automatic req_t rand_req();
		req_t r;
		int kind;
		int span;
		kind = $urandom_range(0, 9);
		span = (kind < 6) ? $urandom_range(1, 1 << 20) : 0;
		r.start_x = $urandom; r.start_y = $urandom;
		r.end_x   = $urandom; r.end_y   = $urandom;
		r.query_x = $urandom; r.query_y = $urandom;
		if (kind < 6) begin
			r.start_x = $signed($urandom_range(0, 2 * span)) - span;
			r.start_y = $signed($urandom_range(0, 2 * span)) - span;
			r.end_x   = $signed($urandom_range(0, 2 * span)) - span;
			r.end_y   = $signed($urandom_range(0, 2 * span)) - span;
			r.query_x = $signed($urandom_range(0, 2 * span)) - span;
			r.query_y = $signed($urandom_range(0, 2 * span)) - span;
		end
		// degenerate segment or query on an endpoint
		if (kind == 6) begin
			r.end_x = r.start_x; r.end_y = r.start_y;
		end
		if (kind == 7) begin
			r.query_x = r.end_x; r.query_y = r.end_y;
		end
		return r;
	endfunction

	// Drive one request and hold it until it is taken; expectation queued on acceptance.
	task automatic issue(req_t r, bit typed, res_t typed_res);
		start <= 1'b1;
		req   <= r;
		do @(posedge clk); while (busy);
		pending_q.push_back(typed ? typed_res : seg_distance(r, tolerance));
		// each cycle idles with probability idle_pct percent
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
	endtask

	// Let the pipeline empty before touching the tolerance.
	task automatic write_tolerance(logic [32:0] v);
		start <= 1'b0;
		wait (pending_q.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		tolerance = v;
	endtask

	// Result checker: the receiver cannot stall, so every done is compared at once.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: dist %0d near %0d part %0d",
						result.distance, result.is_near, result.nearest_part);
			end else begin
				res_t exp_res;
				exp_res = pending_q.pop_front();
				if (result.distance !== exp_res.distance ||
				    result.is_near !== exp_res.is_near ||
				    result.nearest_part !== exp_res.nearest_part) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp dist %0d near %0d part %0d, got %0d %0d %0d",
							exp_res.distance, exp_res.is_near, exp_res.nearest_part,
							result.distance, result.is_near, result.nearest_part);
				end
			end
		end
	end

	// Watchdog: cycles in which neither a request nor a result is taken.
	always @(posedge clk) begin
		if ((start && !busy) || done)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("point_segment_distance_top regression: fail");
			$finish;
		end
	end

	// Directed table: typed result where it is obvious, else predicted.
	typedef struct {
		req_t r;
		bit   typed;
		res_t res;
	} row_t;

	row_t table_rows[$];

	function automatic res_t mk_res(logic [32:0] d, logic n, part_t p);
		res_t o;
		o.distance = d; o.is_near = n; o.nearest_part = p;
		return o;
	endfunction

	initial begin
		int minv, maxv;
		logic [32:0] tol_set[4];
		minv = 32'h8000_0000;
		maxv = 32'h7fff_ffff;
		start = 1'b0; req = '0; cfg_we = 1'b0; cfg_wdata = '0;
		mismatches = 0; quiet_cycles = 0; idle_pct = 6;
		tolerance = TOL_RESET;

		// all zero: degenerate at origin
		table_rows.push_back('{mk_req(0, 0, 0, 0, 0, 0), 1, mk_res(0, 1, PART_START)});
		// query behind the start
		table_rows.push_back('{mk_req(0, 0, 1 << 16, 0, -(2 << 16), 0), 1,
			mk_res(2 << 16, 0, PART_START)});
		// query past the end
		table_rows.push_back('{mk_req(0, 0, 1 << 16, 0, 3 << 16, 0), 1,
			mk_res(2 << 16, 0, PART_END)});
		// interior projection at a quarter
		table_rows.push_back('{mk_req(0, 0, 4 << 16, 0, 1 << 16, 1 << 16), 1,
			mk_res(1 << 16, 1, PART_MID)});
		// exactly at tolerance, just above
		table_rows.push_back('{mk_req(0, 0, 0, 0, 0, 1 << 16), 1, mk_res(1 << 16, 1, PART_START)});
		table_rows.push_back('{mk_req(0, 0, 0, 0, 0, (1 << 16) + 1), 1,
			mk_res((1 << 16) + 1, 0, PART_START)});
		// degenerate segment away from origin
		table_rows.push_back('{mk_req(5, 7, 5, 7, 5, 7), 1, mk_res(0, 1, PART_START)});
		// extremes of every coordinate, then small cases near the origin
		table_rows.push_back('{mk_req(minv, minv, minv, minv, maxv, maxv), 0, '0});
		table_rows.push_back('{mk_req(maxv, maxv, maxv, maxv, minv, minv), 0, '0});
		table_rows.push_back('{mk_req(minv, minv, maxv, maxv, maxv, minv), 0, '0});
		table_rows.push_back('{mk_req(minv, maxv, maxv, minv, minv, minv), 0, '0});
		table_rows.push_back('{mk_req(minv, minv, maxv, minv, maxv, maxv), 0, '0});
		table_rows.push_back('{mk_req(maxv, minv, minv, minv, minv, maxv), 0, '0});
		table_rows.push_back('{mk_req(minv, minv, maxv, maxv, maxv, maxv), 0, '0});
		table_rows.push_back('{mk_req(minv, minv, maxv, maxv, minv, minv), 0, '0});
		table_rows.push_back('{mk_req(-1, -1, 1, 1, 1, -1), 0, '0});
		table_rows.push_back('{mk_req(-1, -1, -1, -1, -1, -1), 1, mk_res(0, 1, PART_START)});
		table_rows.push_back('{mk_req(0, 0, 3, 7, 11, -2), 0, '0});

		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (table_rows[i])
			issue(table_rows[i].r, table_rows[i].typed, table_rows[i].res);

		// tolerance sweep: zero, range top, full 33-bit value, then random
		tol_set[0] = 33'd0;
		tol_set[1] = DIST_MAX;
		tol_set[2] = 33'h1_ffff_ffff;
		tol_set[3] = {1'($urandom_range(0, 1)), $urandom};
		for (int ph = 0; ph < 4; ph++) begin
			write_tolerance(tol_set[ph]);
			idle_pct = (ph == 0) ? 6 : (ph == 1) ? 45 : 0;
			repeat (200) issue(rand_req(), 0, '0);
		end

		start <= 1'b0;
		wait (pending_q.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("point_segment_distance_top regression: pass");
		else
			$display("point_segment_distance_top regression: fail");
		$finish;
	end

endmodule
